// ----- src/csg_pkg.sv -----
// shared types, constants and the quarter-wave cosine table of the sample generator
// no dependencies; imported by the front end, queue, back end and top-level modules

package csg_pkg;

   localparam int INDEX_BITS = 16;
   localparam int PHASE_BITS = 10;
   localparam int QTR        = 1 << (PHASE_BITS - 2);
   localparam int CNT_BITS   = $clog2(PHASE_BITS);
   localparam int FRAC_SHIFT = 29;

   // register indexes on the csr port
   localparam logic [1:0] REG_PERIOD = 2'd0;
   localparam logic [1:0] REG_GAIN   = 2'd1;
   localparam logic [1:0] REG_OFFSET = 2'd2;
   localparam logic [1:0] REG_BITS   = 2'd3;

   localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
   localparam logic [63:0] ONE_Q60 = 64'h1000000000000000;

   typedef struct packed {
      logic [15:0]       period;
      logic [15:0]       gain;
      logic signed [15:0] offset;
      logic [4:0]        bits;
   } csg_cfg_type;

   typedef struct packed {
      logic [15:0] used;
      logic        last;
   } csg_item_type;

   typedef logic [16:0] qcos_table_type [0:QTR];

   function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] pr;
      pr = {64'd0, a} * {64'd0, b};
      return pr[123:60];
   endfunction

   // round(cos(pi/2 * p / QTR) * 32768), taylor series in q60
   function automatic logic [16:0] quarter_cos(input int p);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic [63:0]        rnd;
      x    = mul_q60(PI_Q60 >> 1, 64'(p) << (62 - PHASE_BITS));
      x2   = mul_q60(x, x);
      term = ONE_Q60;
      sum  = $signed(ONE_Q60);
      for (int n = 1; n <= 14; n++) begin
         term = mul_q60(term, x2) / 64'((2 * n - 1) * (2 * n));
         if (n % 2 == 1) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      if (sum < 0) begin
         sum = 64'sd0;
      end
      rnd = (64'(sum) + (64'd1 << 44)) >> 45;
      return rnd[16:0];
   endfunction

   function automatic qcos_table_type build_qcos();
      qcos_table_type t;
      for (int i = 0; i <= QTR; i++) begin
         t[i] = quarter_cos(i);
      end
      return t;
   endfunction

   localparam qcos_table_type QCOS = build_qcos();

   // full-period q1.15 cosine, +1.0 saturates to 32767
   function automatic logic signed [15:0] cos_lookup(input logic [PHASE_BITS-1:0] phase);
      logic [1:0]              quad;
      logic [PHASE_BITS-3:0]   r;
      logic [PHASE_BITS-2:0]   ri;
      logic [PHASE_BITS-2:0]   mi;
      logic signed [17:0]      v;
      quad = phase[PHASE_BITS-1:PHASE_BITS-2];
      r    = phase[PHASE_BITS-3:0];
      ri   = {1'b0, r};
      mi   = (PHASE_BITS-1)'(QTR) - ri;
      case (quad)
         2'd0:    v =  $signed({1'b0, QCOS[ri]});
         2'd1:    v = -$signed({1'b0, QCOS[mi]});
         2'd2:    v = -$signed({1'b0, QCOS[ri]});
         default: v =  $signed({1'b0, QCOS[mi]});
      endcase
      if (v > 18'sd32767) begin
         v = 18'sd32767;
      end
      return v[15:0];
   endfunction

   function automatic logic [15:0] eff_period(input logic [15:0] p);
      return (p == 16'd0) ? 16'd1 : p;
   endfunction

endpackage

// ----- src/csg_front.sv -----
// front end: accepts requests, picks the sample index and keeps the index state
// depends on csg_pkg

module csg_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic                  restart,
   input  logic [15:0]           period,
   output csg_pkg::csg_item_type item
);
   import csg_pkg::*;

   logic [INDEX_BITS-1:0] index_ff, index_in;
   logic [15:0]           n;
   logic                  out_of_range;
   logic [INDEX_BITS-1:0] used;
   logic                  last;

   always_comb begin
      n            = eff_period(period);
      out_of_range = ({16'd0, index_ff} >= {{INDEX_BITS{1'b0}}, n});
      used         = (restart || out_of_range) ? '0 : index_ff;
      // used is below n here, so it fits the period width
      last         = ({16'd0, used} == {{INDEX_BITS{1'b0}}, n - 16'd1});
      index_in     = last ? '0 : used + 1'b1;
      item.used    = 16'({16'd0, used});
      item.last    = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= '0;
      end else if (accept) begin
         index_ff <= index_in;
      end
   end

endmodule

// ----- src/csg_fifo.sv -----
// two-entry queue between front and back end
// depends on csg_pkg

module csg_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  csg_pkg::csg_item_type push_item,
   output logic                  full,
   input  logic                  pop,
   output logic                  not_empty,
   output csg_pkg::csg_item_type pop_item
);
   import csg_pkg::*;

   csg_item_type slot_ff [0:1];
   logic         wr_ptr_ff, rd_ptr_ff;
   logic [1:0]   count_ff;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_item  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

// ----- src/csg_back.sv -----
// back end: phase divider, cosine lookup, gain/offset scaling, clipping, output register
// depends on csg_pkg

module csg_back (
   input  logic                  clock,
   input  logic                  reset,
   input  csg_pkg::csg_cfg_type  cfg,
   input  logic                  item_valid,
   input  csg_pkg::csg_item_type item,
   output logic                  item_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic signed [15:0]    rsp_sample,
   output logic                  rsp_last,
   output logic                  rsp_clip
);
   import csg_pkg::*;

   typedef enum logic [2:0] {S_IDLE, S_DIV, S_TAB, S_MUL1, S_MUL2, S_FIN} state_type;

   state_type               state_ff;
   logic [CNT_BITS-1:0]     cnt_ff;
   logic [16:0]             rem_ff;
   logic [PHASE_BITS-1:0]   quot_ff;
   logic                    last_ff;
   logic signed [15:0]      cos_ff;
   logic signed [33:0]      t_ff;
   logic signed [50:0]      p_ff;
   logic                    valid_ff;
   logic signed [15:0]      sample_ff;
   logic                    olast_ff;
   logic                    clip_ff;

   logic [15:0]             n;
   logic [4:0]              b;
   logic [15:0]             m;
   logic [16:0]             rem2;
   logic                    ge;
   logic signed [50:0]      adj;
   logic signed [21:0]      raw;
   logic signed [21:0]      m_s;
   logic                    out_free;

   always_comb begin
      n = eff_period(cfg.period);
      if (cfg.bits < 5'd2) begin
         b = 5'd2;
      end else if (cfg.bits > 5'd16) begin
         b = 5'd16;
      end else begin
         b = cfg.bits;
      end
      m        = (16'd1 << (b - 5'd1)) - 16'd1;
      rem2     = {rem_ff[15:0], 1'b0};
      ge       = (rem2 >= {1'b0, n});
      // truncate toward zero
      adj      = p_ff + ((p_ff < 0) ? 51'sd536870911 : 51'sd0);
      raw      = 22'(adj >>> FRAC_SHIFT);
      m_s      = $signed({6'd0, m});
      out_free = !valid_ff || rsp_ready;
      item_pop = (state_ff == S_IDLE) && item_valid;
   end

   assign rsp_valid  = valid_ff;
   assign rsp_sample = sample_ff;
   assign rsp_last   = olast_ff;
   assign rsp_clip   = clip_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         // the finish state drives valid itself
         if (valid_ff && rsp_ready && state_ff != S_FIN) begin
            valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (item_valid) begin
                  rem_ff   <= {1'b0, item.used};
                  last_ff  <= item.last;
                  quot_ff  <= '0;
                  cnt_ff   <= '0;
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               rem_ff  <= ge ? rem2 - {1'b0, n} : rem2;
               quot_ff <= {quot_ff[PHASE_BITS-2:0], ge};
               cnt_ff  <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_BITS'(PHASE_BITS - 1)) begin
                  state_ff <= S_TAB;
               end
            end
            S_TAB: begin
               cos_ff   <= cos_lookup(quot_ff);
               state_ff <= S_MUL1;
            end
            S_MUL1: begin
               t_ff     <= $signed({1'b0, cfg.gain}) * cos_ff + (34'(cfg.offset) <<< 15);
               state_ff <= S_MUL2;
            end
            S_MUL2: begin
               p_ff     <= t_ff * $signed({1'b0, m});
               state_ff <= S_FIN;
            end
            S_FIN: begin
               if (out_free) begin
                  valid_ff <= 1'b1;
                  olast_ff <= last_ff;
                  if (raw > m_s) begin
                     sample_ff <= m_s[15:0];
                     clip_ff   <= 1'b1;
                  end else if (raw < -m_s) begin
                     sample_ff <= 16'(-m_s);
                     clip_ff   <= 1'b1;
                  end else begin
                     sample_ff <= raw[15:0];
                     clip_ff   <= 1'b0;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ----- src/cosine_sample_generator.sv -----
// cosine sample generator: one result per request; the back end finishes one sample
// before it pops the next request, going through pop, the bit-serial phase divider (one
// quotient bit per cycle), lookup, two multiply steps and the clip stage
// a two-entry queue lets requests be taken while the back end is busy
// synchronous active-high reset clears the sample index, queue and output valid and
// loads the register defaults (period 64, gain 1.0, offset 0, 12 bits)

module cosine_sample_generator (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] restart, [7:1] zero
   // sample stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] sample
   output logic        rsp_tlast,   // last sample of the period
   output logic        rsp_tuser,   // [0] clipped
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import csg_pkg::*;

   // configuration registers
   logic [15:0] period_ff;
   logic [15:0] gain_ff;
   logic [15:0] offset_ff;
   logic [4:0]  bits_ff;
   logic        wr_en;
   logic [1:0]  reg_sel;

   csg_cfg_type  cfg;
   csg_item_type front_item;
   csg_item_type queue_item;
   logic         req_accept;
   logic         queue_full;
   logic         queue_valid;
   logic         queue_pop;
   logic signed [15:0] sample;

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr[3:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= 16'd64;
         gain_ff   <= 16'd16384;
         offset_ff <= 16'd0;
         bits_ff   <= 5'd12;
      end else if (wr_en) begin
         case (reg_sel)
            REG_PERIOD: period_ff <= csr_pwdata[15:0];
            REG_GAIN:   gain_ff   <= csr_pwdata[15:0];
            REG_OFFSET: offset_ff <= csr_pwdata[15:0];
            REG_BITS:   bits_ff   <= csr_pwdata[4:0];
            default:    ;
         endcase
      end
   end

   // register readback
   always_comb begin
      case (reg_sel)
         REG_PERIOD: csr_prdata = {16'd0, period_ff};
         REG_GAIN:   csr_prdata = {16'd0, gain_ff};
         REG_OFFSET: csr_prdata = {16'd0, offset_ff};
         REG_BITS:   csr_prdata = {27'd0, bits_ff};
         default:    csr_prdata = 32'd0;
      endcase
   end

   assign cfg.period = period_ff;
   assign cfg.gain   = gain_ff;
   assign cfg.offset = $signed(offset_ff);
   assign cfg.bits   = bits_ff;

   // a request transfer happens whenever req_tvalid is high and the queue has room
   assign req_tready = !queue_full;
   assign req_accept = req_tvalid && req_tready;

   csg_front u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_accept),
      .restart (req_tdata[0]),
      .period  (period_ff),
      .item    (front_item)
   );

   csg_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_item (front_item),
      .full      (queue_full),
      .pop       (queue_pop),
      .not_empty (queue_valid),
      .pop_item  (queue_item)
   );

   csg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (queue_valid),
      .item       (queue_item),
      .item_pop   (queue_pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_sample (sample),
      .rsp_last   (rsp_tlast),
      .rsp_clip   (rsp_tuser)
   );

   assign rsp_tdata = sample;

endmodule

// ----- src/csg_checker.sv -----
// port-level checks for the cosine sample generator, bound to the top level
// depends on nothing beyond the top-level ports

module csg_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        rsp_tuser
);

   // a stalled sample stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped while stalled");

   // a stalled sample keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast)
         && $stable(rsp_tuser))
      else $error("rsp payload changed while stalled");

   // a clipped sample sits at plus or minus full scale, never zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata != 16'd0)
      else $error("clipped sample is zero");

   // no sample is offered right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

endmodule

bind cosine_sample_generator csg_checker u_csg_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

// ----- tb/tb_cosine_sample_generator.sv -----
// self-checking testbench for the cosine sample generator
// depends on csg_pkg (register indexes) and the cosine_sample_generator rtl

module tb_cosine_sample_generator;
   timeunit 1ns;
   timeprecision 1ps;
   import csg_pkg::*;

   localparam int LIMIT_CYCLES = 400000;
   localparam int DRAIN_CYCLES = 40;
   localparam int ITEM_TARGET  = 900;

   typedef struct {
      logic signed [15:0] sample;
      logic               last;
      logic               clip;
   } sample_type;

   // directed row kinds
   typedef enum logic [1:0] {ROW_REG, ROW_ITEM, ROW_PINNED} row_kind_type;

   typedef struct {
      row_kind_type       kind;
      logic [1:0]         idx;
      logic [31:0]        value;
      logic               restart;
      logic signed [15:0] sample;
      logic               last;
      logic               clip;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;   // [0] restart, [7:1] zero
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;          // [15:0] sample
   logic        rsp_tlast;
   logic        rsp_tuser;          // [0] clipped
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = 4'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   cosine_sample_generator uut (.*);

   always #1 clock = ~clock;

   // model copy of the registers and the sample index
   logic [15:0]        m_period;
   logic [15:0]        m_gain;
   logic signed [15:0] m_level;
   logic [4:0]         m_bits;
   logic [15:0]        m_index;

   int         qcos [0:256];
   sample_type pending_samples[$];
   sample_type pinned_samples[int];   // typed-in results keyed by transfer number
   int         accepted = 0;
   int         sent = 0;
   int         mismatches = 0;
   int         cycles = 0;
   bit         quiet = 1'b0;           // no idling in the closing stretch

   function automatic logic [63:0] q60_mul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      return prod[123:60];
   endfunction

   // rounded q1.15 cosine over a quarter wave, taylor series in q60
   function automatic int quarter_wave(input int p);
      logic [63:0]        ang;
      logic [63:0]        ang2;
      logic [63:0]        term;
      logic signed [63:0] acc;
      ang  = q60_mul(64'h3243F6A8885A308D >> 1, 64'(p) << 52);
      ang2 = q60_mul(ang, ang);
      term = 64'h1000000000000000;
      acc  = 64'sh1000000000000000;
      for (int k = 1; k <= 14; k++) begin
         term = q60_mul(term, ang2) / 64'((2 * k - 1) * (2 * k));
         acc  = (k % 2) ? acc - $signed(term) : acc + $signed(term);
      end
      if (acc < 0) acc = 0;
      return int'((64'(acc) + (64'd1 << 44)) >> 45);
   endfunction

   function automatic int cos_q15(input int phase);
      int r;
      int v;
      r = phase % 256;
      case (phase / 256)
         0:       v = qcos[r];
         1:       v = -qcos[256 - r];
         2:       v = -qcos[r];
         default: v = qcos[256 - r];
      endcase
      return (v > 32767) ? 32767 : v;
   endfunction

   // next sample for one accepted request, advances the model index
   function automatic sample_type next_sample(input logic restart);
      sample_type res;
      longint     n;
      longint     used;
      longint     fs;
      longint     raw;
      int         nb;
      n    = (m_period == 0) ? 1 : m_period;
      used = m_index;
      if (restart || used >= n) used = 0;
      nb = m_bits;
      if (nb < 2) nb = 2;
      if (nb > 16) nb = 16;
      fs  = (64'sd1 <<< (nb - 1)) - 1;
      raw = (longint'(m_gain) * cos_q15(int'((used << 10) / n)) * fs
             + longint'(m_level) * fs * 32768) / (64'sd1 <<< 29);
      res.clip = 1'b0;
      if (raw > fs) begin
         raw = fs;
         res.clip = 1'b1;
      end else if (raw < -fs) begin
         raw = -fs;
         res.clip = 1'b1;
      end
      res.sample = raw[15:0];
      res.last   = (used == n - 1);
      m_index    = res.last ? 16'd0 : 16'(used + 1);
      return res;
   endfunction

   // request side: predict each transfer
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         sample_type s;
         s = next_sample(req_tdata[0]);
         if (pinned_samples.exists(accepted)) s = pinned_samples[accepted];
         pending_samples.push_back(s);
         accepted++;
      end
   end

   // sample side: compare with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_samples.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected sample %0d", $signed(rsp_tdata));
         end else begin
            sample_type w;
            w = pending_samples.pop_front();
            if (rsp_tdata !== w.sample || rsp_tlast !== w.last || rsp_tuser !== w.clip) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("sample mismatch: want %0d/%b/%b got %0d/%b/%b",
                           w.sample, w.last, w.clip, $signed(rsp_tdata), rsp_tlast,
                           rsp_tuser);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("tb_cosine_sample_generator: errors");
         $finish;
      end
   end

   // receiver stalls in random bursts
   initial begin
      @(negedge reset);
      forever begin
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
         if (!quiet && $urandom_range(0, 2) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end
      end
   end

   // register write: setup then access, model updated at the write edge, then idle
   // before the next write
   task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_PERIOD: m_period = value[15:0];
         REG_GAIN:   m_gain   = value[15:0];
         REG_OFFSET: m_level  = value[15:0];
         default:    m_bits   = value[4:0];
      endcase
      @(posedge clock);
   endtask

   // wait for every sample to come back, then let the pipeline settle
   task automatic drain();
      if (req_tvalid) req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // one request transfer, valid stays high for a following item
   task automatic send_item(input logic restart);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, restart};
      do @(posedge clock); while (!req_tready);
      sent++;
   endtask

   row_type plan[$];

   function automatic row_type reg_row(input logic [1:0] idx, input logic [31:0] value);
      row_type r;
      r = '{kind: ROW_REG, idx: idx, value: value, restart: 0, sample: 0, last: 0, clip: 0};
      return r;
   endfunction

   function automatic row_type item_row(input logic restart);
      row_type r;
      r = '{kind: ROW_ITEM, idx: 0, value: 0, restart: restart, sample: 0, last: 0, clip: 0};
      return r;
   endfunction

   function automatic row_type pinned_row(input logic restart, input int s, input logic l,
                                          input logic c);
      row_type r;
      r = '{kind: ROW_PINNED, idx: 0, value: 0, restart: restart, sample: 16'(s),
            last: l, clip: c};
      return r;
   endfunction

   initial begin
      for (int i = 0; i <= 256; i++) qcos[i] = quarter_wave(i);
      m_period = 16'd64;
      m_gain   = 16'd16384;
      m_level  = 16'sd0;
      m_bits   = 5'd12;
      m_index  = 16'd0;

      // directed part: defaults, one-sample and zero periods, minus one, clip, resolution
      plan = '{pinned_row(0, 2046, 0, 0), item_row(0), item_row(1), item_row(0),
               reg_row(REG_PERIOD, 1), pinned_row(0, 2046, 1, 0), item_row(0),
               reg_row(REG_PERIOD, 0), pinned_row(0, 2046, 1, 0), item_row(1),
               reg_row(REG_PERIOD, 2), item_row(0), item_row(0), item_row(0),
               reg_row(REG_GAIN, 65535), reg_row(REG_OFFSET, 32767), reg_row(REG_BITS, 16),
               pinned_row(1, 32767, 0, 1), item_row(0),
               reg_row(REG_GAIN, 0), reg_row(REG_OFFSET, 32'h8000),
               pinned_row(1, -32767, 0, 1),
               reg_row(REG_BITS, 0), item_row(0), reg_row(REG_BITS, 31), item_row(0),
               reg_row(REG_BITS, 2), reg_row(REG_GAIN, 16384), reg_row(REG_OFFSET, 0),
               reg_row(REG_PERIOD, 65535), item_row(1), item_row(0), item_row(0)};

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_REG) begin
            drain();
            write_reg(plan[i].idx, plan[i].value);
         end else begin
            if (plan[i].kind == ROW_PINNED)
               pinned_samples[sent] = '{plan[i].sample, plan[i].last, plan[i].clip};
            send_item(plan[i].restart);
         end
      end

      // random phases: new settings while idle, then a run of requests
      while (sent < ITEM_TARGET) begin
         drain();
         if (sent > ITEM_TARGET * 4 / 5) quiet = 1'b1;
         case ($urandom_range(0, 5))
            0:       write_reg(REG_PERIOD, $urandom_range(0, 65535));
            1:       write_reg(REG_PERIOD, $urandom_range(0, 4));
            default: write_reg(REG_PERIOD, $urandom_range(1, 150));
         endcase
         case ($urandom_range(0, 3))
            0:       write_reg(REG_GAIN, $urandom_range(0, 1) ? 65535 : 0);
            default: write_reg(REG_GAIN, $urandom_range(0, 65535));
         endcase
         case ($urandom_range(0, 3))
            0:       write_reg(REG_OFFSET, 0);
            1:       write_reg(REG_OFFSET, $urandom_range(0, 1) ? 32'h7fff : 32'h8000);
            default: write_reg(REG_OFFSET, $urandom_range(0, 65535));
         endcase
         write_reg(REG_BITS, $urandom_range(0, 31));
         repeat ($urandom_range(20, 120)) send_item($urandom_range(0, 19) == 0);
      end

      drain();
      if (mismatches == 0) begin
         $display("tb_cosine_sample_generator: clean");
      end else begin
         $display("tb_cosine_sample_generator: errors");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
src/csg_pkg.sv
src/csg_front.sv
src/csg_fifo.sv
src/csg_back.sv
src/cosine_sample_generator.sv
src/csg_checker.sv
tb/tb_cosine_sample_generator.sv
